// ----- rtl/x931_aes_random_generator_defines.svh -----
// Assertion macros for the generator RTL.
`ifndef X931_AES_RANDOM_GENERATOR_DEFINES_SVH
`define X931_AES_RANDOM_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define X931_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("x931 check failed");
`define X931_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("x931 check failed");
`else
`define X931_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define X931_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/x931_pkg.sv -----
// Shared constants and helpers for the X9.31 AES random generator.
package x931_pkg;

    localparam int MAX_REQUEST_BYTES_DEF = 64;
    localparam int AES_ROUNDS = 10;

    localparam logic CFG_KEY_LOW  = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

    localparam logic [127:0] SEED_CONST = {
        64'h20474E5250206472,
        64'h6143676E69727053
    };

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

// ----- rtl/x931_aes_core.sv -----
// Round-iterative AES-128 encryptor, substituting one 32-bit digit per cycle.
module x931_aes_core
    import x931_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] din,
    input  logic [127:0] key,
    output logic         busy,
    output logic         done,
    output logic [127:0] dout
);

    `include "x931_aes_random_generator_defines.svh"

    localparam logic [2:0] PH_MIX = 3'd4;

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [2:0]   phase_reg, phase_next;
    logic [3:0]   round_reg, round_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] rk_reg, rk_next;
    logic [127:0] sr;
    logic [127:0] mc;
    logic [127:0] nk;
    logic [31:0]  kt;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                sr[8*(i+4*c) +: 8] = st_reg[8*(i+4*((c+i)%4)) +: 8];
            end
        end
    end

    always_comb
    begin
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++)
        begin
            a0 = sr[32*c +: 8];
            a1 = sr[32*c+8 +: 8];
            a2 = sr[32*c+16 +: 8];
            a3 = sr[32*c+24 +: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            mc[32*c +: 8]    = a0 ^ al ^ xtime(a0 ^ a1);
            mc[32*c+8 +: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
            mc[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            mc[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
    end

    always_comb
    begin
        kt = sub_word({rk_reg[103:96], rk_reg[127:104]}) ^ {24'd0, rcon_reg};
        nk[31:0]   = rk_reg[31:0] ^ kt;
        nk[63:32]  = rk_reg[63:32] ^ nk[31:0];
        nk[95:64]  = rk_reg[95:64] ^ nk[63:32];
        nk[127:96] = rk_reg[127:96] ^ nk[95:64];
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        phase_next = phase_reg;
        round_next = round_reg;
        rcon_next  = rcon_reg;
        st_next    = st_reg;
        rk_next    = rk_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = 3'd0;
            round_next = 4'd1;
            rcon_next  = 8'h01;
            st_next    = din ^ key;
            rk_next    = key;
        end
        else if (busy_reg)
        begin
            if (phase_reg == PH_MIX)
            begin
                st_next    = ((round_reg == 4'(AES_ROUNDS)) ? sr : mc) ^ nk;
                rk_next    = nk;
                rcon_next  = xtime(rcon_reg);
                phase_next = 3'd0;
                round_next = round_reg + 4'd1;
                if (round_reg == 4'(AES_ROUNDS))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
            else
            begin
                st_next    = {sub_word(st_reg[31:0]), st_reg[127:32]};
                phase_next = phase_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 3'd0;
            round_reg <= 4'd1;
            rcon_reg  <= 8'h01;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
            round_reg <= round_next;
            rcon_reg  <= rcon_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        rk_reg <= rk_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign dout = st_reg;

    `X931_ASSERT_IMPLY(a_start_idle, clk, rst_n, start, !busy_reg)
    `X931_ASSERT_IMPLY(a_round_range, clk, rst_n, busy_reg,
        (round_reg >= 4'd1) && (round_reg <= 4'(AES_ROUNDS)) && (phase_reg <= PH_MIX))
    `X931_ASSERT_IMPLY(a_done_idle, clk, rst_n, done_reg, !busy_reg)

endmodule

// ----- rtl/x931_aes_random_generator.sv -----
// ANSI X9.31 style random generator on AES-128: request sequencing and output register.
// Usage: load the key through cfg_we/cfg_index/cfg_data while the block is idle
// (index 0 key bytes 0..7, index 1 key bytes 8..15). Each input beat carries a
// 128-bit timestamp and a byte count (saturated at MAX_REQUEST_BYTES); it yields
// ceil(count/8) output beats of 64 bits, valid_bytes telling how many low bytes
// count and last marking the final beat. A zero count gives no output beat.
// Each AES encryption runs from start to result in the shared round-iterative
// core (a load step, then per round four 32-bit substitution digits and one
// mixing step). A block needs three chained encryptions plus one emit step;
// its first output beat shows once the IV and X encryptions are done, and a
// request holds the input until all its blocks are through, with a seeding
// encryption first on the first request after reset.
// in_ready is high only between requests.
// Reset clears the key to zero, loads the seed with its ASCII constant and marks
// it unencrypted. The result sits in an output register: a stalled receiver
// holds the next block before its seed update until the beat is taken.
module x931_aes_random_generator
    import x931_pkg::*;
#(
    parameter int MAX_REQUEST_BYTES = MAX_REQUEST_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] time_low,
    input  logic [63:0] time_high,
    input  logic [6:0]  byte_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] random_word,
    output logic [3:0]  valid_bytes,
    output logic        last,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int RW = $clog2(MAX_REQUEST_BYTES + 1);
    localparam int BW = (RW > 7) ? RW : 7;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SEED  = 3'd1;
    localparam logic [2:0] S_NEXT  = 3'd2;
    localparam logic [2:0] S_IVENC = 3'd3;
    localparam logic [2:0] S_XENC  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_SENC  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [63:0]   key_low_reg, key_high_reg;
    logic [127:0]  seed_reg, seed_next;
    logic          seed_ready_reg, seed_ready_next;
    logic [127:0]  iv_reg, iv_next;
    logic [127:0]  x_reg, x_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic          ov_reg, ov_next;
    logic [63:0]   word_reg, word_next;
    logic [3:0]    vb_reg, vb_next;
    logic          last_reg, last_next;

    logic          core_start;
    logic [127:0]  core_din;
    logic          core_busy;
    logic          core_done;
    logic [127:0]  core_dout;

    logic [BW-1:0] bc_ext;
    logic [RW-1:0] bc_sat;
    logic [3:0]    take;
    logic [RW-1:0] rem_after;

    assign bc_ext    = BW'(byte_count);
    assign bc_sat    = (bc_ext > BW'(MAX_REQUEST_BYTES)) ? RW'(MAX_REQUEST_BYTES)
                                                         : RW'(bc_ext);
    assign take      = (rem_reg >= RW'(8)) ? 4'd8 : rem_reg[3:0];
    assign rem_after = rem_reg - RW'(take);

    x931_aes_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (core_start),
        .din   (core_din),
        .key   ({key_high_reg, key_low_reg}),
        .busy  (core_busy),
        .done  (core_done),
        .dout  (core_dout)
    );

    always_comb
    begin
        state_next      = state_reg;
        seed_next       = seed_reg;
        seed_ready_next = seed_ready_reg;
        iv_next         = iv_reg;
        x_next          = x_reg;
        rem_next        = rem_reg;
        ov_next         = ov_reg && !out_ready;
        word_next       = word_reg;
        vb_next         = vb_reg;
        last_next       = last_reg;
        core_start      = 1'b0;
        core_din        = iv_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    iv_next  = {time_high, time_low};
                    rem_next = bc_sat;
                    if (!seed_ready_reg)
                    begin
                        core_start = 1'b1;
                        core_din   = seed_reg;
                        state_next = S_SEED;
                    end
                    else
                    begin
                        state_next = S_NEXT;
                    end
                end
            end
            S_SEED:
            begin
                if (core_done)
                begin
                    seed_next       = core_dout;
                    seed_ready_next = 1'b1;
                    state_next      = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (rem_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    core_start = 1'b1;
                    core_din   = iv_reg;
                    state_next = S_IVENC;
                end
            end
            S_IVENC:
            begin
                if (core_done)
                begin
                    iv_next    = core_dout;
                    core_start = 1'b1;
                    core_din   = core_dout ^ seed_reg;
                    state_next = S_XENC;
                end
            end
            S_XENC:
            begin
                if (core_done)
                begin
                    x_next     = core_dout;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    word_next  = x_reg[63:0];
                    vb_next    = take;
                    last_next  = (rem_after == '0);
                    rem_next   = rem_after;
                    core_start = 1'b1;
                    core_din   = iv_reg ^ x_reg;
                    state_next = S_SENC;
                end
            end
            S_SENC:
            begin
                if (core_done)
                begin
                    seed_next  = core_dout;
                    state_next = S_NEXT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            seed_reg       <= SEED_CONST;
            seed_ready_reg <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            seed_reg       <= seed_next;
            seed_ready_reg <= seed_ready_next;
            ov_reg         <= ov_next;
            if (cfg_we && (cfg_index == CFG_KEY_LOW))
            begin
                key_low_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_KEY_HIGH))
            begin
                key_high_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        iv_reg   <= iv_next;
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        word_reg <= word_next;
        vb_reg   <= vb_next;
        last_reg <= last_next;
    end

    assign in_ready    = (state_reg == S_IDLE) && !core_busy;
    assign out_valid   = ov_reg;
    assign random_word = word_reg;
    assign valid_bytes = vb_reg;
    assign last        = last_reg;

endmodule
